// ===== rtl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg - shared types and constants of the cover scaler address generator
// Dimension limits, fixed-point widths and the beat carried down the divider
// chain.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int MAX_SRC_WIDTH  = 1280;
  localparam int MAX_SRC_HEIGHT = 1024;
  localparam int MAX_DST_DIM    = 4096;
  localparam int FRAC_BITS      = 16;

  localparam int SW_W   = 11;  // source size registers
  localparam int DW_W   = 13;  // screen size registers
  localparam int SCL_W  = 29;  // 13.16 scale, at most 4096 << 16
  localparam int OFF_W  = 25;  // signed centering offset
  localparam int DIF_W  = 24;  // positive (d - offset) magnitude
  localparam int Q_W    = 12;  // quotient bits resolved by the chain
  localparam int REM_W  = 41;  // remainder and shifted divisor
  localparam int NCELL  = Q_W;

  // register indexes
  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_DST_W = 3'd2;
  localparam logic [2:0] REG_DST_H = 3'd3;

  // derived geometry shared by sequencer and datapath
  typedef struct packed {
    logic [SCL_W-1:0]        scale;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic [SW_W-1:0]         iw;
    logic [SW_W-1:0]         ih;
  } geom_t;

  // one beat in the divider chain
  typedef struct packed {
    logic             vld;
    logic             neg_x;
    logic             ovf_x;
    logic [REM_W-1:0] rem_x;
    logic [Q_W-1:0]   q_x;
    logic             neg_y;
    logic             ovf_y;
    logic [REM_W-1:0] rem_y;
    logic [Q_W-1:0]   q_y;
    logic [REM_W-1:0] dvs;
  } beat_t;

endpackage

// ===== rtl/csa_cfg.sv =====
// ----------------------------------------------------------------------------
// csa_cfg - configuration registers and geometry sequencer
// Holds the four size registers and, after reset or a write to one of them,
// works out the scale (bit-serial divider) and the centering offsets.
// ----------------------------------------------------------------------------
module csa_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [csa_pkg::DW_W-1:0]      cfg_data,
  output logic                          busy,
  output csa_pkg::geom_t                geom
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVX = 3'd1;
  localparam logic [2:0] ST_DIVY = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OFF  = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;

  localparam int SCL_W = csa_pkg::SCL_W;
  localparam int SW_W  = csa_pkg::SW_W;
  localparam int DW_W  = csa_pkg::DW_W;
  localparam int PRD_W = SW_W + SCL_W;

  logic [SW_W-1:0] src_w_r, src_h_r;
  logic [DW_W-1:0] dst_w_r, dst_h_r;
  logic [2:0]      state_r, state_nxt;
  logic [4:0]      cnt_r;
  logic [SCL_W-1:0] dvd_r, quo_r, qx_r, scale_r;
  logic [SW_W:0]   rem_r;
  logic [PRD_W-1:0] prd_x_r, prd_y_r;
  logic signed [csa_pkg::OFF_W-1:0] off_x_r, off_y_r;

  logic [SW_W-1:0] iw, ih, dsr;
  logic [DW_W-1:0] w, h;
  logic [SW_W+1:0] trial;
  logic            take;
  logic [SCL_W-1:0] quo_nxt, smax;
  logic signed [csa_pkg::OFF_W-1:0] tx, ty;

  // saturated dimensions
  always_comb begin
    iw = (src_w_r == '0) ? SW_W'(1) :
         (src_w_r > SW_W'(csa_pkg::MAX_SRC_WIDTH)) ? SW_W'(csa_pkg::MAX_SRC_WIDTH) : src_w_r;
    ih = (src_h_r == '0) ? SW_W'(1) :
         (src_h_r > SW_W'(csa_pkg::MAX_SRC_HEIGHT)) ? SW_W'(csa_pkg::MAX_SRC_HEIGHT) : src_h_r;
    w  = (dst_w_r == '0) ? DW_W'(1) :
         (dst_w_r > DW_W'(csa_pkg::MAX_DST_DIM)) ? DW_W'(csa_pkg::MAX_DST_DIM) : dst_w_r;
    h  = (dst_h_r == '0) ? DW_W'(1) :
         (dst_h_r > DW_W'(csa_pkg::MAX_DST_DIM)) ? DW_W'(csa_pkg::MAX_DST_DIM) : dst_h_r;
  end

  // one restoring divide step
  always_comb begin
    dsr     = (state_r == ST_DIVY) ? ih : iw;
    trial   = {rem_r, dvd_r[SCL_W-1]};
    take    = trial >= {1'b0, 1'b0, dsr};
    quo_nxt = {quo_r[SCL_W-2:0], take};
    smax    = (quo_nxt > qx_r) ? quo_nxt : qx_r;
    // centering differences, truncated toward zero on halving
    tx = $signed({1'b0, 11'd0, w}) - $signed({1'b0, prd_x_r[PRD_W-1:csa_pkg::FRAC_BITS]});
    ty = $signed({1'b0, 11'd0, h}) - $signed({1'b0, prd_y_r[PRD_W-1:csa_pkg::FRAC_BITS]});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_LOAD: state_nxt = ST_DIVX;
      ST_DIVX: if (cnt_r == 5'(SCL_W-1)) state_nxt = ST_DIVY;
      ST_DIVY: if (cnt_r == 5'(SCL_W-1)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OFF;
      ST_OFF:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && cfg_index <= csa_pkg::REG_DST_H) state_nxt = ST_LOAD;
  end

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SW_W'(1280);
      src_h_r <= SW_W'(1024);
      dst_w_r <= DW_W'(1024);
      dst_h_r <= DW_W'(768);
    end else if (cfg_we) begin
      unique case (cfg_index)
        csa_pkg::REG_SRC_W: src_w_r <= cfg_data[SW_W-1:0];
        csa_pkg::REG_SRC_H: src_h_r <= cfg_data[SW_W-1:0];
        csa_pkg::REG_DST_W: dst_w_r <= cfg_data;
        csa_pkg::REG_DST_H: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and serial divider; the dividend is loaded once the new
  // register value is in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
      dvd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD) begin
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= '0;
        dvd_r <= {w, 16'd0};
      end else if (state_r == ST_DIVX || state_r == ST_DIVY) begin
        if (cnt_r == 5'(SCL_W-1)) begin
          cnt_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
          dvd_r <= {h, 16'd0};
        end else begin
          cnt_r <= cnt_r + 5'd1;
          rem_r <= take ? (SW_W+1)'(trial - {2'b0, dsr}) : trial[SW_W:0];
          quo_r <= quo_nxt;
          dvd_r <= {dvd_r[SCL_W-2:0], 1'b0};
        end
      end
    end
  end

  // scale, scaled sizes and offsets
  always_ff @(posedge clk) begin
    if (state_r == ST_DIVX && cnt_r == 5'(SCL_W-1)) qx_r <= quo_nxt;
    if (state_r == ST_DIVY && cnt_r == 5'(SCL_W-1)) begin
      scale_r <= (smax == '0) ? SCL_W'(1) : smax;
    end
    if (state_r == ST_MUL) begin
      prd_x_r <= PRD_W'(iw) * PRD_W'(scale_r);
      prd_y_r <= PRD_W'(ih) * PRD_W'(scale_r);
    end
    if (state_r == ST_OFF) begin
      off_x_r <= (tx + $signed({24'd0, tx[csa_pkg::OFF_W-1]})) >>> 1;
      off_y_r <= (ty + $signed({24'd0, ty[csa_pkg::OFF_W-1]})) >>> 1;
    end
  end

  assign busy = (state_r != ST_IDLE) || cfg_we;
  assign geom = '{scale: scale_r, off_x: off_x_r, off_y: off_y_r, iw: iw, ih: ih};

endmodule

// ===== rtl/csa_cell.sv =====
// ----------------------------------------------------------------------------
// csa_cell - one restoring division cell of the coordinate chain
// Resolves one quotient bit for both axes and hands the beat on, with the
// divisor shifted one place right.
// ----------------------------------------------------------------------------
module csa_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  csa_pkg::beat_t din,
  output csa_pkg::beat_t dout
);

  csa_pkg::beat_t nxt, q_r;
  logic tx, ty;

  always_comb begin
    nxt      = din;
    tx       = din.rem_x >= din.dvs;
    ty       = din.rem_y >= din.dvs;
    nxt.rem_x = tx ? din.rem_x - din.dvs : din.rem_x;
    nxt.rem_y = ty ? din.rem_y - din.dvs : din.rem_y;
    nxt.q_x  = {din.q_x[csa_pkg::Q_W-2:0], tx};
    nxt.q_y  = {din.q_y[csa_pkg::Q_W-2:0], ty};
    nxt.dvs  = din.dvs >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_r <= '0;
    else q_r <= nxt;
  end

  assign dout = q_r;

endmodule

// ===== rtl/cover_scale_source_address.sv =====
// ----------------------------------------------------------------------------
// cover_scale_source_address - cover-crop nearest-neighbor source addresser
// Maps a screen pixel to the clamped source pixel and its linear index.
// ----------------------------------------------------------------------------
// One pixel per clock: a beat is taken whenever start is high and busy low,
// and its result shows on out_valid for one cycle once it has passed the
// entry register, the chain of 12 divider cells and the clamp and index
// registers; results cannot be held off. Busy is high in the cycle of any
// register write, and after reset or a write to a size register also while
// the sequencer runs a load state, a 29-step serial divide per axis for the
// scale, a multiply state and an offset state.
module cover_scale_source_address (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_dst_x,
  input  logic [11:0] in_dst_y,
  output logic        out_valid,
  output logic [10:0] out_src_x,
  output logic [9:0]  out_src_y,
  output logic [20:0] out_src_index,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int NC = csa_pkg::NCELL;

  csa_pkg::geom_t geom;
  csa_pkg::beat_t chain [0:NC];
  csa_pkg::beat_t b0;
  logic signed [25:0] dx, dy;
  logic [11:0] sx_q, sy_q;
  logic        cl_vld_r, out_vld_r;
  logic [10:0] cl_x_r, sx_r;
  logic [9:0]  cl_y_r, sy_r;
  logic [20:0] idx_r;
  csa_pkg::beat_t fin;

  csa_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .busy(busy), .geom(geom)
  );

  // entry: offset subtract, sign and overflow checks
  always_comb begin
    dx = $signed({14'd0, in_dst_x}) - 26'($signed(geom.off_x));
    dy = $signed({14'd0, in_dst_y}) - 26'($signed(geom.off_y));
    b0.vld   = start && !busy;
    b0.neg_x = dx[25];
    b0.neg_y = dy[25];
    b0.ovf_x = ({1'b0, dx[23:0], 4'd0} >= {1'b0, geom.scale});
    b0.ovf_y = ({1'b0, dy[23:0], 4'd0} >= {1'b0, geom.scale});
    b0.rem_x = {1'b0, dx[23:0], 16'd0};
    b0.rem_y = {1'b0, dy[23:0], 16'd0};
    b0.q_x   = '0;
    b0.q_y   = '0;
    b0.dvs   = {1'b0, geom.scale, 11'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) chain[0] <= '0;
    else chain[0] <= b0;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    csa_cell u_cell (.clk(clk), .rst_n(rst_n), .din(chain[i]), .dout(chain[i+1]));
  end

  // clamp to the image
  always_comb begin
    fin  = chain[NC];
    sx_q = fin.neg_x ? 12'd0 :
           (fin.ovf_x || fin.q_x >= {1'b0, geom.iw}) ? 12'({1'b0, geom.iw} - 12'd1) : fin.q_x;
    sy_q = fin.neg_y ? 12'd0 :
           (fin.ovf_y || fin.q_y >= {1'b0, geom.ih}) ? 12'({1'b0, geom.ih} - 12'd1) : fin.q_y;
  end

  always_ff @(posedge clk) begin
    cl_x_r <= sx_q[10:0];
    cl_y_r <= sy_q[9:0];
    sx_r   <= cl_x_r;
    sy_r   <= cl_y_r;
    idx_r  <= 21'(21'(cl_y_r) * 21'(geom.iw)) + 21'(cl_x_r);
    if (!rst_n) begin
      cl_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cl_vld_r  <= fin.vld;
      out_vld_r <= cl_vld_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_src_x     = sx_r;
  assign out_src_y     = sy_r;
  assign out_src_index = idx_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of the cover scaler source address generator
// Drives screen pixels through the start/busy handshake and checks every
// address beat against an in-bench model of the cover-crop mapping or a value
// given in the table. Starts with a short directed table, then runs random
// pixels over a series of register settings. The table holds the extremes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int LIMIT      = 300000;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    logic [10:0] sx;
    logic [9:0]  sy;
    logic [20:0] idx;
  } addr_t;

  typedef struct {
    bit          is_cfg;
    bit          typed;
    logic [2:0]  reg_i;
    logic [12:0] val;
    logic [11:0] x;
    logic [11:0] y;
    addr_t       want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [11:0] in_dst_x;
  logic [11:0] in_dst_y;
  logic        out_valid;
  logic [10:0] out_src_x;
  logic [9:0]  out_src_y;
  logic [20:0] out_src_index;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  // register copies of the model
  logic [10:0] m_src_w, m_src_h;
  logic [12:0] m_dst_w, m_dst_h;

  addr_t  pending_addr[$];
  int     n_errors;
  int     n_cycles;
  bit     quiet;
  row_t   dir_rows[$];

  cover_scale_source_address dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dst_x(in_dst_x), .in_dst_y(in_dst_y),
    .out_valid(out_valid), .out_src_x(out_src_x), .out_src_y(out_src_y),
    .out_src_index(out_src_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat(longint v, longint hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // one axis: offset-corrected coordinate divided by the scale, clamped
  function automatic longint map_axis_pos(longint d, longint off, longint scl,
                                          longint size);
    longint s;
    s = ((d - off) * 65536) / scl;
    if (s < 0) s = 0;
    if (s >= size) s = size - 1;
    return s;
  endfunction

  // cover-crop mapping of one screen pixel under the current registers
  function automatic addr_t map_pixel(logic [11:0] x, logic [11:0] y);
    longint iw, ih, w, h, scl, s2, sw, sh, ox, oy, sx, sy;
    addr_t  a;
    iw  = sat(longint'(m_src_w), longint'(csa_pkg::MAX_SRC_WIDTH));
    ih  = sat(longint'(m_src_h), longint'(csa_pkg::MAX_SRC_HEIGHT));
    w   = sat(longint'(m_dst_w), longint'(csa_pkg::MAX_DST_DIM));
    h   = sat(longint'(m_dst_h), longint'(csa_pkg::MAX_DST_DIM));
    scl = (w * 65536) / iw;
    s2  = (h * 65536) / ih;
    if (s2 > scl) scl = s2;
    if (scl < 1) scl = 1;
    sw  = (iw * scl) >> 16;
    sh  = (ih * scl) >> 16;
    ox  = (w - sw) / 2;
    oy  = (h - sh) / 2;
    sx  = map_axis_pos(longint'(x), ox, scl, iw);
    sy  = map_axis_pos(longint'(y), oy, scl, ih);
    a.sx  = sx[10:0];
    a.sy  = sy[9:0];
    a.idx = 21'(sy * iw + sx);
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
             n_cycles);
    n_errors++;
  endtask

  // send one pixel beat; start stays high after acceptance
  task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit typed,
                            addr_t want);
    int gap;
    if (!quiet && $urandom_range(99) < 11) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_dst_x <= x;
    in_dst_y <= y;
    do @(posedge clk); while (busy);
    pending_addr.push_back(typed ? want : map_pixel(x, y));
  endtask

  // wait for every address, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_addr.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] i, logic [12:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (i)
      csa_pkg::REG_SRC_W: m_src_w = v[10:0];
      csa_pkg::REG_SRC_H: m_src_h = v[10:0];
      csa_pkg::REG_DST_W: m_dst_w = v;
      csa_pkg::REG_DST_H: m_dst_h = v;
      default: ;
    endcase
  endtask

  function automatic row_t cfg_row(logic [2:0] i, logic [12:0] v);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.reg_i = i; r.val = v;
    return r;
  endfunction

  function automatic row_t pix_row(logic [11:0] x, logic [11:0] y, bit typed,
                                   logic [10:0] ex, logic [9:0] ey,
                                   logic [20:0] ei);
    row_t r;
    r = '{default: '0};
    r.x = x; r.y = y; r.typed = typed;
    r.want.sx = ex; r.want.sy = ey; r.want.idx = ei;
    return r;
  endfunction

  // address checker; results cannot be held off
  always @(posedge clk) begin
    addr_t e;
    if (rst_n && out_valid) begin
      if (pending_addr.size() == 0) begin
        report("unexpected beat, src_index", 32'(out_src_index), 32'd0);
      end else begin
        e = pending_addr.pop_front();
        if (out_src_x !== e.sx) report("src_x", 32'(out_src_x), 32'(e.sx));
        if (out_src_y !== e.sy) report("src_y", 32'(out_src_y), 32'(e.sy));
        if (out_src_index !== e.idx) begin
          report("src_index", 32'(out_src_index), 32'(e.idx));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    addr_t none;
    int    n_items;
    logic [12:0] v;
    none = '{default: '0};
    n_errors = 0; n_cycles = 0; quiet = 0;
    rst_n = 0; start = 0; in_dst_x = 0; in_dst_y = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    m_src_w = 1280; m_src_h = 1024; m_dst_w = 1024; m_dst_h = 768;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: reset geometry, saturation, ignored index, extremes
    dir_rows.push_back(pix_row(0, 0, 1, 0, 31, 39680));
    dir_rows.push_back(pix_row(4095, 4095, 1, 1279, 1023, 1310719));
    dir_rows.push_back(pix_row(4095, 0, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(0, 4095, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(512, 384, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_UNUSED, 13'h1FFF));
    dir_rows.push_back(pix_row(1023, 767, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(csa_pkg::REG_SRC_W, 0));
    dir_rows.push_back(cfg_row(csa_pkg::REG_SRC_H, 0));
    dir_rows.push_back(cfg_row(csa_pkg::REG_DST_W, 0));
    dir_rows.push_back(cfg_row(csa_pkg::REG_DST_H, 0));
    dir_rows.push_back(pix_row(0, 0, 1, 0, 0, 0));
    dir_rows.push_back(pix_row(4095, 4095, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(csa_pkg::REG_SRC_W, 13'h1FFF));
    dir_rows.push_back(cfg_row(csa_pkg::REG_SRC_H, 13'h07FF));
    dir_rows.push_back(cfg_row(csa_pkg::REG_DST_W, 13'h1FFF));
    dir_rows.push_back(cfg_row(csa_pkg::REG_DST_H, 13'h1FFF));
    dir_rows.push_back(pix_row(0, 0, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(4095, 4095, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(2048, 2048, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(csa_pkg::REG_DST_W, 1));
    dir_rows.push_back(cfg_row(csa_pkg::REG_DST_H, 4096));
    dir_rows.push_back(pix_row(0, 2047, 0, 0, 0, 0));
    dir_rows.push_back(pix_row(4095, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].reg_i, dir_rows[i].val);
      else send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
                      dir_rows[i].want);
    end

    // random phases, each under a fresh register setting
    n_items = 0;
    for (int ph = 0; ph < 9; ph++) begin
      for (int r = 0; r < 4; r++) begin
        case ($urandom_range(3))
          0: v = 13'($urandom);
          1: v = (r < 2) ? 13'($urandom_range(1, 1280)) : 13'($urandom_range(1, 4096));
          2: v = (r < 2) ? 13'($urandom_range(1, 64)) : 13'($urandom_range(1, 64));
          default: v = (r < 2) ? 13'(r == 0 ? 1280 : 1024) : 13'(4096);
        endcase
        write_reg(3'(r), v);
      end
      quiet = (ph == 4);
      for (int k = 0; k < 50; k++) begin
        logic [11:0] x, y;
        if ($urandom_range(3) == 0) begin
          x = 12'($urandom); y = 12'($urandom);
        end else begin
          x = 12'($urandom_range(0, (m_dst_w == 0) ? 0 :
                                   (m_dst_w > 4096 ? 4095 : m_dst_w - 1)));
          y = 12'($urandom_range(0, (m_dst_h == 0) ? 0 :
                                   (m_dst_h > 4096 ? 4095 : m_dst_h - 1)));
        end
        send_pixel(x, y, 0, none);
        n_items++;
        // hold off until the pipe is empty, once
        if (ph == 2 && k == 25) drain();
      end
    end
    quiet = 0;

    drain();
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== cover_scale_source_address.f =====
rtl/csa_pkg.sv
rtl/csa_cfg.sv
rtl/csa_cell.sv
rtl/cover_scale_source_address.sv
tb/tb_top.sv
